/* rtl/core/tcq_pkg.sv */
`default_nettype none
package tcq_pkg;

  localparam int SAMPLES_PER_AXIS = 5;
  localparam int DIV              = SAMPLES_PER_AXIS - 2;

  localparam int COORD_W   = 12;
  localparam int SUM_W     = 17;
  localparam int CNT_W     = $clog2(SAMPLES_PER_AXIS + 1);
  localparam int ATT_W     = 5;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES_PER_AXIS);

  // floor(2^SUM_W / DIV); estimate is exact or one low
  localparam int             RECIP_K = SUM_W;
  localparam logic [SUM_W:0] RECIP   = (SUM_W+1)'((2**RECIP_K) / DIV);

  localparam logic [CMD_W-1:0] CMD_X   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_Y   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_GAVE_UP  = 2'd1;
  localparam logic [ST_W-1:0] ST_RELEASED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGREE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT   = 2'd2;

  localparam logic [COORD_W-1:0] MIN_COORD_RST = 12'd100;
  localparam logic [COORD_W-1:0] AGREE_RST     = 12'd100;
  localparam logic [ATT_W-1:0]   MAX_ATT_RST   = 5'd20;

  typedef struct packed {
    logic [COORD_W-1:0] min_coord;
    logic [COORD_W-1:0] agree;
    logic [ATT_W-1:0]   max_att;
  } tcq_cfg_t;

  // trimmed sums of a finished group, or a pen release
  typedef struct packed {
    logic             rel;
    logic [SUM_W-1:0] tx;
    logic [SUM_W-1:0] ty;
  } tcq_ev_t;

  // trimmed sums with quotient estimates
  typedef struct packed {
    logic               rel;
    logic [SUM_W-1:0]   tx;
    logic [SUM_W-1:0]   ty;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
  } tcq_quo_t;

  function automatic logic [COORD_W-1:0] fix_quot(input logic [SUM_W-1:0]   t,
                                                   input logic [COORD_W-1:0] q0);
    logic [SUM_W-1:0] r;
    r = t - SUM_W'(q0) * SUM_W'(DIV);
    if (r >= SUM_W'(DIV)) begin
      return q0 + COORD_W'(1);
    end
    return q0;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tcq_accum.sv */
`default_nettype none
module tcq_accum import tcq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CMD_W-1:0]   cmd_i,
  input  wire logic [COORD_W-1:0] sample_i,
  output logic                    ev_valid_o,
  input  wire logic               ev_ready_i,
  output tcq_ev_t                 ev_o
);

  logic [SUM_W-1:0]   xs_q, xs_d, ys_q, ys_d;
  logic [COORD_W-1:0] xmin_q, xmin_d, xmax_q, xmax_d;
  logic [COORD_W-1:0] ymin_q, ymin_d, ymax_q, ymax_d;
  logic [CNT_W-1:0]   xcnt_q, xcnt_d, ycnt_q, ycnt_d;
  logic               ev_valid_q, ev_valid_d;
  tcq_ev_t            ev_q, ev_d;
  logic               accept, emit, is_smp;

  assign in_ready_o = !ev_valid_q || ev_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  always_comb begin
    xs_d   = xs_q;
    xmin_d = xmin_q;
    xmax_d = xmax_q;
    xcnt_d = xcnt_q;
    ys_d   = ys_q;
    ymin_d = ymin_q;
    ymax_d = ymax_q;
    ycnt_d = ycnt_q;
    ev_d   = ev_q;
    emit   = 1'b0;
    is_smp = 1'b0;
    if (accept) begin
      unique case (cmd_i)
        CMD_X: begin
          is_smp = 1'b1;
          if (xcnt_q < CNT_FULL) begin
            xs_d   = xs_q + SUM_W'(sample_i);
            xmin_d = (sample_i < xmin_q) ? sample_i : xmin_q;
            xmax_d = (sample_i > xmax_q) ? sample_i : xmax_q;
            xcnt_d = xcnt_q + CNT_W'(1);
          end
        end
        CMD_Y: begin
          is_smp = 1'b1;
          if (ycnt_q < CNT_FULL) begin
            ys_d   = ys_q + SUM_W'(sample_i);
            ymin_d = (sample_i < ymin_q) ? sample_i : ymin_q;
            ymax_d = (sample_i > ymax_q) ? sample_i : ymax_q;
            ycnt_d = ycnt_q + CNT_W'(1);
          end
        end
        CMD_REL: begin
          emit    = 1'b1;
          ev_d.rel = 1'b1;
          ev_d.tx  = '0;
          ev_d.ty  = '0;
        end
        default: ;
      endcase
    end
    if (is_smp && xcnt_d == CNT_FULL && ycnt_d == CNT_FULL) begin
      emit     = 1'b1;
      ev_d.rel = 1'b0;
      ev_d.tx  = xs_d - SUM_W'(xmin_d) - SUM_W'(xmax_d);
      ev_d.ty  = ys_d - SUM_W'(ymin_d) - SUM_W'(ymax_d);
    end
    if (emit) begin
      xs_d   = '0;
      xmin_d = '1;
      xmax_d = '0;
      xcnt_d = '0;
      ys_d   = '0;
      ymin_d = '1;
      ymax_d = '0;
      ycnt_d = '0;
    end
    ev_valid_d = emit || (ev_valid_q && !ev_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q       <= '0;
      xmin_q     <= '1;
      xmax_q     <= '0;
      xcnt_q     <= '0;
      ys_q       <= '0;
      ymin_q     <= '1;
      ymax_q     <= '0;
      ycnt_q     <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      xs_q       <= xs_d;
      xmin_q     <= xmin_d;
      xmax_q     <= xmax_d;
      xcnt_q     <= xcnt_d;
      ys_q       <= ys_d;
      ymin_q     <= ymin_d;
      ymax_q     <= ymax_d;
      ycnt_q     <= ycnt_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

endmodule
`default_nettype wire

/* rtl/core/tcq_div.sv */
`default_nettype none
module tcq_div import tcq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire tcq_ev_t ev_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output tcq_quo_t     quo_o
);

  logic     valid_q, valid_d;
  tcq_quo_t quo_q, quo_d;
  logic     accept;

  // quotient by reciprocal multiply, may be one low
  function automatic logic [COORD_W-1:0] est_quot(input logic [SUM_W-1:0] t);
    logic [2*SUM_W:0] p;
    p = (2*SUM_W+1)'(t) * (2*SUM_W+1)'(RECIP);
    return p[RECIP_K +: COORD_W];
  endfunction

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign quo_o       = quo_q;

  always_comb begin
    quo_d = quo_q;
    if (accept) begin
      quo_d.rel = ev_i.rel;
      quo_d.tx  = ev_i.tx;
      quo_d.ty  = ev_i.ty;
      quo_d.qx  = est_quot(ev_i.tx);
      quo_d.qy  = est_quot(ev_i.ty);
    end
    valid_d = accept || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

/* rtl/core/tcq_qual.sv */
`default_nettype none
module tcq_qual import tcq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tcq_quo_t quo_i,
  input  wire tcq_cfg_t cfg_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [COORD_W-1:0] x_o,
  output logic [COORD_W-1:0] y_o,
  output logic [ST_W-1:0]    status_o
);

  logic [COORD_W-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic               have_q, have_d;
  logic [ATT_W-1:0]   att_q, att_d, att_inc;
  logic               valid_q, valid_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [ST_W-1:0]    st_q, st_d;
  logic [COORD_W-1:0] rx, ry, dx, dy;
  logic [COORD_W:0]   sx, sy;
  logic               accept, low, agree;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign status_o    = st_q;

  always_comb begin
    rx      = fix_quot(quo_i.tx, quo_i.qx);
    ry      = fix_quot(quo_i.ty, quo_i.qy);
    dx      = (first_x_q > rx) ? first_x_q - rx : rx - first_x_q;
    dy      = (first_y_q > ry) ? first_y_q - ry : ry - first_y_q;
    agree   = (dx < cfg_i.agree) && (dy < cfg_i.agree);
    low     = (rx < cfg_i.min_coord) || (ry < cfg_i.min_coord);
    sx      = {1'b0, first_x_q} + {1'b0, rx};
    sy      = {1'b0, first_y_q} + {1'b0, ry};
    att_inc = att_q + ATT_W'(1);

    first_x_d = first_x_q;
    first_y_d = first_y_q;
    have_d    = have_q;
    att_d     = att_q;
    x_d       = x_q;
    y_d       = y_q;
    st_d      = st_q;
    valid_d   = valid_q && !out_ready_i;

    if (accept) begin
      if (quo_i.rel) begin
        first_x_d = '0;
        first_y_d = '0;
        have_d    = 1'b0;
        att_d     = '0;
        x_d       = '0;
        y_d       = '0;
        st_d      = ST_RELEASED;
        valid_d   = 1'b1;
      end else if (!low && !have_q) begin
        first_x_d = rx;
        first_y_d = ry;
        have_d    = 1'b1;
      end else if (!low && agree) begin
        have_d  = 1'b0;
        att_d   = '0;
        x_d     = sx[COORD_W:1];
        y_d     = sy[COORD_W:1];
        st_d    = ST_OK;
        valid_d = 1'b1;
      end else begin
        have_d = 1'b0;
        if (att_inc >= cfg_i.max_att) begin
          att_d   = '0;
          x_d     = '0;
          y_d     = '0;
          st_d    = ST_GAVE_UP;
          valid_d = 1'b1;
        end else begin
          att_d = att_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      have_q    <= 1'b0;
      att_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      have_q    <= have_d;
      att_q     <= att_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    st_q <= st_d;
  end

endmodule
`default_nettype wire

/* rtl/core/touch_coordinate_qualifier.sv */
// Touch coordinate qualifier.
// Input stream: one word per converter sample or pen event. tuser carries the
// command (X sample, Y sample, pen released), tdata[11:0] the sample.
// Output stream: tdata = {y_coord, x_coord}, tuser = status (ok, gave up,
// released). Words that complete nothing produce no output word.
// Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
// (0 min coordinate, 1 agree range, 2 max attempts); write only while idle.
// Pipeline: accumulate stage, reciprocal-multiply stage, qualify and output
// register. Results pass through each stage register in turn; one input word
// is taken every cycle unless stalled. Each stage moves when the one after it
// is empty or moving, so a stalled receiver holds the output word stable and
// back-pressure reaches s_axis_tready only once every stage holds a word.
// Reset clears the sample groups, the stored first reading, the attempt
// counter and all valid flags, and loads the register defaults (100, 100, 20).
`default_nettype none
module touch_coordinate_qualifier import tcq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,  // sample[11:0], zero pad
  input  wire logic [CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // x_coord[11:0], y_coord[23:12]
  output logic [ST_W-1:0]           m_axis_tuser,  // status[1:0]
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  tcq_cfg_t           cfg_q, cfg_d;
  tcq_ev_t            ev;
  tcq_quo_t           quo;
  logic               ev_valid, ev_ready, quo_valid, quo_ready;
  logic [COORD_W-1:0] x_coord, y_coord;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_COORD: cfg_d.min_coord = cfg_data_i[COORD_W-1:0];
        CFG_AGREE:     cfg_d.agree     = cfg_data_i[COORD_W-1:0];
        CFG_MAX_ATT:   cfg_d.max_att   = cfg_data_i[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_coord <= MIN_COORD_RST;
      cfg_q.agree     <= AGREE_RST;
      cfg_q.max_att   <= MAX_ATT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tcq_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .sample_i   (s_axis_tdata[COORD_W-1:0]),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  tcq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ev_valid),
    .in_ready_o  (ev_ready),
    .ev_i        (ev),
    .out_valid_o (quo_valid),
    .out_ready_i (quo_ready),
    .quo_o       (quo)
  );

  tcq_qual u_qual (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (quo_valid),
    .in_ready_o  (quo_ready),
    .quo_i       (quo),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_o         (x_coord),
    .y_o         (y_coord),
    .status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {y_coord, x_coord};

endmodule
`default_nettype wire

/* rtl/core/tcq_checker.sv */
`default_nettype none
module tcq_checker import tcq_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [23:0]          m_axis_tdata,
  input wire logic [ST_W-1:0]      m_axis_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // an empty or draining output register lets the whole pipe move
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free output register");

  // give-up and release words carry zero coordinates
  a_zero_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("non-ok result with nonzero coordinates");

  // a result word never shows the unused status code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tuser == ST_OK || m_axis_tuser == ST_GAVE_UP || m_axis_tuser == ST_RELEASED)
    else $error("bad status code");

endmodule

bind touch_coordinate_qualifier tcq_checker u_tcq_checker (.*);
`default_nettype wire
